// ===== sv/hx2u_pkg.sv =====
// Package for the hex text to 32-bit parser: codes, state struct and constants.
package hx2u_pkg;

    localparam int DEFAULT_MAX_DIGITS = 8;
    localparam int CHAR_W             = 8;
    localparam int VALUE_W            = 32;
    localparam int STATUS_W           = 2;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;

    // Accumulator value after "16", checked before '#'.
    localparam logic [VALUE_W-1:0] PREFIX_16 = 32'h0000_0016;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_TOKEN = 3'd1,
        PH_TRAIL = 3'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Parser control state carried from word to word.
    typedef struct packed {
        phase_t     phase;
        logic [1:0] token_position;
        logic       prefix_taken;
        logic [1:0] digit_seen_count;
        logic       format_error;
    } ctrl_t;

    localparam ctrl_t CTRL_RESET = '{
        phase:            PH_LEAD,
        token_position:   2'd0,
        prefix_taken:     1'b0,
        digit_seen_count: 2'd0,
        format_error:     1'b0
    };

endpackage

// ===== sv/hex_text_to_u32_parser.sv =====
// Top level of the streaming hex text to 32-bit unsigned parser.
// A terminator word is held in the input register, and its result then in the result register.
// Throughput: one character word per cycle, except that a terminator stalls while the result register is full and
// held; the state update is one short step. The result register frees the input side while a result waits to be taken.
// Reset (rst_n low, asynchronous): pipeline empty, parser in leading white space.
module hex_text_to_u32_parser
    import hx2u_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CHAR_W-1:0]  char_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0] value
);

    localparam int SIG_W = $clog2(MAX_DIGITS + 2);

    logic                 s1_valid_reg;
    logic [CHAR_W-1:0]    s1_char_reg;
    ctrl_t                ctrl_reg, ctrl_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [SIG_W-1:0]     sig_reg, sig_next;
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic                 step_done;
    status_t              step_status;
    logic [VALUE_W-1:0]   step_value;
    logic                 advance;
    logic                 accept;

    hx2u_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .SIG_W      (SIG_W)
    ) u_step (
        .char_code  (s1_char_reg),
        .ctrl       (ctrl_reg),
        .acc        (acc_reg),
        .sig        (sig_reg),
        .ctrl_next  (ctrl_next),
        .acc_next   (acc_next),
        .sig_next   (sig_next),
        .done       (step_done),
        .status     (step_status),
        .value      (step_value)
    );

    // A terminator needs a free result register; other words always move on.
    assign advance  = s1_valid_reg && (!step_done || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            acc_reg       <= '0;
            sig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                ctrl_reg <= ctrl_next;
                acc_reg  <= acc_next;
                sig_reg  <= sig_next;
            end

            if (advance && step_done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_char_reg <= char_code;
        if (advance && step_done)
        begin
            status_reg <= step_status;
            value_reg  <= step_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> value_reg == '0)
        else $error("error result with nonzero value");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && s1_char_reg == CH_NUL)
        else $error("input stalled without a blocked terminator");

    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_done |=> out_valid_reg)
        else $error("terminator did not produce a result");

    a_reset_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_done |=> ctrl_reg == CTRL_RESET && acc_reg == '0 && sig_reg == '0)
        else $error("parser state not cleared after terminator");

endmodule

// ===== sv/hx2u_step.sv =====
// One character step of the parser: next state and the result on the terminator.
module hx2u_step
    import hx2u_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
    parameter int SIG_W      = $clog2(MAX_DIGITS + 2)
)
(
    input  logic [CHAR_W-1:0]  char_code,
    input  ctrl_t              ctrl,
    input  logic [VALUE_W-1:0] acc,
    input  logic [SIG_W-1:0]   sig,
    output ctrl_t              ctrl_next,
    output logic [VALUE_W-1:0] acc_next,
    output logic [SIG_W-1:0]   sig_next,
    output logic               done,
    output status_t            status,
    output logic [VALUE_W-1:0] value
);

    localparam logic [SIG_W-1:0] SIG_MAX = SIG_W'(MAX_DIGITS);
    localparam logic [SIG_W-1:0] SIG_SAT = SIG_W'(MAX_DIGITS + 1);

    logic       is_space;
    logic       is_hex;
    logic [3:0] digit;
    logic       prefix_hit;

    always_comb
    begin
        is_space = char_code inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B, 8'h0C};
        is_hex   = 1'b1;
        digit    = 4'd0;
        case (char_code) inside
            [8'h30:8'h39]: digit = 4'(char_code - 8'h30);
            [8'h61:8'h66]: digit = 4'(char_code - 8'h61 + 8'd10);
            [8'h41:8'h46]: digit = 4'(char_code - 8'h41 + 8'd10);
            default:       is_hex = 1'b0;
        endcase
    end

    always_comb
    begin
        prefix_hit = !ctrl.prefix_taken && (
            ((char_code == CH_X_LO || char_code == CH_X_UP) && ctrl.token_position == 2'd1
             && ctrl.digit_seen_count == 2'd1 && acc == '0) ||
            (char_code == CH_HASH && ctrl.token_position == 2'd2
             && ctrl.digit_seen_count == 2'd2 && acc == PREFIX_16) ||
            (char_code == CH_DOLLAR && ctrl.token_position == 2'd0));
    end

    always_comb
    begin
        ctrl_next = ctrl;
        acc_next  = acc;
        sig_next  = sig;
        done      = 1'b0;
        status    = ST_OK;
        value     = '0;

        if (char_code == CH_NUL)
        begin
            done = 1'b1;
            if (ctrl.format_error || ctrl.digit_seen_count == 2'd0)
                status = ST_FORMAT;
            else if (sig > SIG_MAX)
                status = ST_RANGE;
            else
                value = acc;
            ctrl_next = CTRL_RESET;
            acc_next  = '0;
            sig_next  = '0;
        end
        else if (!ctrl.format_error)
        begin
            case (ctrl.phase)
                PH_LEAD, PH_TOKEN:
                begin
                    if (ctrl.phase == PH_LEAD && is_space)
                    begin
                        ctrl_next = ctrl;
                    end
                    else
                    begin
                        ctrl_next.phase = PH_TOKEN;
                        if (ctrl.token_position != 2'd3)
                            ctrl_next.token_position = ctrl.token_position + 2'd1;
                        if (prefix_hit)
                        begin
                            ctrl_next.prefix_taken     = 1'b1;
                            ctrl_next.digit_seen_count = 2'd0;
                            acc_next = '0;
                            sig_next = '0;
                        end
                        else if (is_hex)
                        begin
                            acc_next = {acc[VALUE_W-5:0], digit};
                            if (ctrl.digit_seen_count != 2'd3)
                                ctrl_next.digit_seen_count = ctrl.digit_seen_count + 2'd1;
                            if ((sig != '0 || digit != 4'd0) && sig < SIG_SAT)
                                sig_next = sig + SIG_W'(1);
                        end
                        else if (is_space)
                            ctrl_next.phase = PH_TRAIL;
                        else
                            ctrl_next.format_error = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_space)
                        ctrl_next.format_error = 1'b1;
                end
                default:
                begin
                    ctrl_next.format_error = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== sim/hex_text_to_u32_parser_test.sv =====
// Testbench for the hex text to 32-bit parser: directed and random strings, predictor and result checks.
`timescale 1ns / 1ps

module hex_text_to_u32_parser_test;
    import hx2u_pkg::*;

    localparam int MAX_DIGITS     = DEFAULT_MAX_DIGITS;
    localparam int RANDOM_CHARS   = 1250;
    localparam int HOLD_OFF       = 400;
    localparam int HOLD_AT_RESULT = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] value;
    } parse_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CHAR_W-1:0]   char_code = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;

    logic [CHAR_W-1:0] char_queue[$];
    parse_result_t     expected_parses[$];
    int                mismatches     = 0;
    int                results_seen   = 0;
    int                idle_cycles    = 0;
    int                send_gap       = 0;
    int                recv_wait      = 0;
    int                hold_cycles    = 0;
    int                send_run       = 0;
    int                recv_run       = 0;
    bit                send_busy      = 1'b0;
    bit                recv_busy      = 1'b0;

    string hex_chars   = "0123456789abcdefABCDEF";
    string blank_chars = " \011\012\013\014\015";

    // predictor state
    phase_t             prs_phase   = PH_LEAD;
    logic [1:0]         tok_pos     = '0;
    bit                 prefix_seen = 1'b0;
    logic [VALUE_W-1:0] acc         = '0;
    logic [1:0]         digit_cnt   = '0;
    logic [3:0]         sig_digits  = '0;
    bit                 fmt_err     = 1'b0;

    hex_text_to_u32_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value     (value)
    );

    always #1 clk = ~clk;

    function automatic bit is_blank(input logic [CHAR_W-1:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // 16 means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return 5'd16;
    endfunction

    // stretches of idle-free traffic and stretches of random gaps, the kind of each stretch drawn at random
    function automatic int draw_wait(inout int run_left, inout bit busy_mode);
        if (run_left == 0)
        begin
            run_left  = $urandom_range(16, 96);
            busy_mode = $urandom_range(0, 2) != 0;
        end
        run_left--;
        return busy_mode ? $urandom_range(0, 10) : 0;
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic [4:0]    d;
        logic [1:0]    pos;
        bit            in_token;
        parse_result_t r;
        if (c == CH_NUL)
        begin
            if (fmt_err || digit_cnt == 0)
                r = '{ST_FORMAT, '0};
            else if (sig_digits > MAX_DIGITS)
                r = '{ST_RANGE, '0};
            else
                r = '{ST_OK, acc};
            expected_parses.push_back(r);
            prs_phase   = PH_LEAD;
            tok_pos     = '0;
            prefix_seen = 1'b0;
            fmt_err     = 1'b0;
            acc         = '0;
            digit_cnt   = '0;
            sig_digits  = '0;
        end
        else if (!fmt_err)
        begin
            in_token = 1'b0;
            case (prs_phase)
                PH_LEAD:
                begin
                    if (!is_blank(c))
                    begin
                        prs_phase = PH_TOKEN;
                        in_token  = 1'b1;
                    end
                end
                PH_TOKEN: in_token = 1'b1;
                default:  if (!is_blank(c)) fmt_err = 1'b1;
            endcase
            if (in_token)
            begin
                d   = hex_digit(c);
                pos = tok_pos;
                if (tok_pos < 3) tok_pos++;
                if (!prefix_seen &&
                    (((c == CH_X_LO || c == CH_X_UP) && pos == 1 && digit_cnt == 1 &&
                      acc == '0) ||
                     (c == CH_HASH && pos == 2 && digit_cnt == 2 && acc == PREFIX_16) ||
                     (c == CH_DOLLAR && pos == 0)))
                begin
                    prefix_seen = 1'b1;
                    acc         = '0;
                    digit_cnt   = '0;
                    sig_digits  = '0;
                end
                else if (d < 16)
                begin
                    acc = {acc[VALUE_W-5:0], d[3:0]};
                    if (digit_cnt < 3) digit_cnt++;
                    if ((sig_digits > 0 || d != 0) && sig_digits < MAX_DIGITS + 1)
                        sig_digits++;
                end
                else if (is_blank(c))
                    prs_phase = PH_TRAIL;
                else
                    fmt_err = 1'b1;
            end
        end
    endtask

    task automatic add_string(input string s);
        foreach (s[i]) char_queue.push_back(s[i]);
        char_queue.push_back(CH_NUL);
    endtask

    task automatic add_random_string();
        logic [CHAR_W-1:0] txt[$];
        int                kind;
        int                n_digits;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // raw noise, any nonzero byte
            repeat ($urandom_range(0, 12)) txt.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) txt.push_back(blank_chars[$urandom_range(0, 5)]);
            if (kind == 1) txt.push_back($urandom_range(0, 1) ? "+" : "-");
            case ($urandom_range(0, 4))
                1:
                begin
                    txt.push_back("0");
                    txt.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                end
                2:
                begin
                    txt.push_back("1");
                    txt.push_back("6");
                    txt.push_back(CH_HASH);
                end
                3: txt.push_back(CH_DOLLAR);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) txt.push_back("0");
            n_digits = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8);
            repeat (n_digits) txt.push_back(hex_chars[$urandom_range(0, 21)]);
            repeat ($urandom_range(0, 2)) txt.push_back(blank_chars[$urandom_range(0, 5)]);
            if (kind == 2 && txt.size() != 0)
                txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(1, 255));
        end
        foreach (txt[i]) char_queue.push_back(txt[i]);
        char_queue.push_back(CH_NUL);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_code <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_char(char_code);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_queue.size() != 0)
                begin
                    char_code <= char_queue.pop_front();
                    in_valid  <= 1'b1;
                    send_gap   = draw_wait(send_run, send_busy);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t exp;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_parses.size() == 0)
                begin
                    $error("unexpected result: status %0d value %h", status, value);
                    mismatches++;
                end
                else
                begin
                    exp = expected_parses.pop_front();
                    if (status != exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, status);
                        mismatches++;
                    end
                    if (value != exp.value)
                    begin
                        $error("value: expected %h, got %h", exp.value, value);
                        mismatches++;
                    end
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen == HOLD_AT_RESULT) hold_cycles = HOLD_OFF;
                recv_wait = draw_wait(recv_run, recv_busy);
            end
            else if (recv_wait > 0)
                recv_wait--;
            if (hold_cycles > 0) hold_cycles--;
            out_stall <= (recv_wait > 0) || (hold_cycles > 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int base;
        add_string("");
        add_string(" \011\012\013\014\015");
        add_string("0");
        add_string("FFFFFFFF");
        add_string("100000000");
        add_string("0000000000aB");
        add_string("0x");
        add_string("0XcD");
        add_string("16#7f");
        add_string("$dead");
        add_string("+1");
        add_string("-1");
        add_string("  12\011 ");
        add_string("12 3");
        add_string("0x0x1");
        add_string("1x2");
        add_string("16#");
        add_string("123456789g");
        add_string("0x123456789");
        add_string("12$");
        add_string("\377\200");
        base = char_queue.size();
        while (char_queue.size() < base + RANDOM_CHARS) add_random_string();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (char_queue.size() != 0 || in_valid || expected_parses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_parses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hx2u_pkg.sv
sv/hx2u_step.sv
sv/hex_text_to_u32_parser.sv
sim/hex_text_to_u32_parser_test.sv
